@@ src/aesr_pkg.sv @@
// shared types, s-box table and field arithmetic for the aes round pipeline
package aesr_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int BYTES   = 16;

    typedef enum logic [1:0] {
        MODE_ADD_KEY = 2'd0,
        MODE_FULL    = 2'd1,
        MODE_FINAL   = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    // one block in flight: operation, working state and its round key
    typedef struct packed {
        logic [1:0]         mode;
        logic [BLOCK_W-1:0] state;
        logic [BLOCK_W-1:0] key;
    } t_item;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // multiply by x in gf(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // one mixcolumns column, top to bottom row
    function automatic logic [31:0] mix_column(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        d0 = xtime(a0);
        d1 = xtime(a1);
        d2 = xtime(a2);
        d3 = xtime(a3);
        return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
                a0 ^ d1 ^ d2 ^ a2 ^ a3,
                a0 ^ a1 ^ d2 ^ d3 ^ a3,
                d0 ^ a0 ^ a1 ^ a2 ^ d3};
    endfunction

endpackage

@@ src/aes_encrypt_round_core.sv @@
// top level of the pipelined single aes-128 encryption round
// Applies one AES round (add key only, full round, or final round without mixcolumns;
// mode 3 acts as add key only) to a 128-bit row-major state, byte 0 in the top bits of
// i_state_high. Three register stages: s-box lookup, shiftrows/mixcolumns, then
// addroundkey into the output register. A request is taken every cycle while the
// pipeline moves; each request passes the sub, mix and key registers in turn, and its
// result is presented from the key stage's output register. Each stage holds its
// request while the stage after it is full and stalled, so up to three requests are in
// flight and none is dropped or repeated.
// o_in_ready is combinational from i_out_ready through the three stage ready terms.
module aes_encrypt_round_core
    import aesr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [HALF_W-1:0] i_state_high,
    input  logic [HALF_W-1:0] i_state_low,
    input  logic [HALF_W-1:0] i_round_key_high,
    input  logic [HALF_W-1:0] i_round_key_low,
    // result side
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [HALF_W-1:0] o_result_high,
    output logic [HALF_W-1:0] o_result_low
);

    t_item              w_in_item;
    // sub stage to mix stage
    logic               w_s1_valid;
    logic               w_s2_ready;
    t_item              w_s1_item;
    // mix stage to key stage
    logic               w_s2_valid;
    logic               w_s3_ready;
    t_item              w_s2_item;
    logic [BLOCK_W-1:0] w_block;

    assign w_in_item.mode  = i_mode;
    assign w_in_item.state = {i_state_high, i_state_low};
    assign w_in_item.key   = {i_round_key_high, i_round_key_low};

    // subbytes
    aesr_sub_stage u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (w_in_item),
        .o_valid (w_s1_valid),
        .i_ready (w_s2_ready),
        .o_item  (w_s1_item)
    );

    // shiftrows and mixcolumns
    aesr_mix_stage u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s2_ready),
        .i_item  (w_s1_item),
        .o_valid (w_s2_valid),
        .i_ready (w_s3_ready),
        .o_item  (w_s2_item)
    );

    // addroundkey and output register
    aesr_key_stage u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s3_ready),
        .i_item  (w_s2_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_block (w_block)
    );

    assign o_result_high = w_block[BLOCK_W-1:HALF_W];
    assign o_result_low  = w_block[HALF_W-1:0];

`ifndef SYNTH
    // a stalled first stage keeps its request
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_valid && !w_s2_ready) |=> (w_s1_valid && $stable(w_s1_item)))
        else $error("sub stage lost or changed a stalled request");

    // a stalled second stage keeps its request
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_valid && !w_s3_ready) |=> (w_s2_valid && $stable(w_s2_item)))
        else $error("mix stage lost or changed a stalled request");

    // back pressure only when every stage is full
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_s1_valid && w_s2_valid && o_out_valid && !i_out_ready))
        else $error("input stalled while the pipeline has room");

    // add key only passes the state straight through the first stage
    a_add_key_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode == MODE_ADD_KEY)
            |=> (w_s1_item.state == $past(w_in_item.state)))
        else $error("add key request altered by the sub stage");
`endif

endmodule

@@ src/aesr_sub_stage.sv @@
// first pipeline stage: subbytes through sixteen s-box lookups for full and final rounds
module aesr_sub_stage
    import aesr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item = i_item;
        if (i_item.mode == MODE_FULL || i_item.mode == MODE_FINAL) begin
            for (int i = 0; i < BYTES; i++) begin
                n_item.state[i*8 +: 8] = SBOX[i_item.state[i*8 +: 8]];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ src/aesr_mix_stage.sv @@
// second pipeline stage: shiftrows for full and final rounds and, for full rounds, mixcolumns
module aesr_mix_stage
    import aesr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic         r_valid;
    t_item        r_item;
    t_item        n_item;
    logic [7:0]   w_in    [BYTES];
    logic [7:0]   w_shift [BYTES];
    logic [7:0]   w_mix   [BYTES];
    logic [31:0]  w_col;

    always_comb begin
        // byte k is counted from the top end of the block, byte 0 topmost
        for (int k = 0; k < BYTES; k++) begin
            w_in[k] = i_item.state[(BYTES-1-k)*8 +: 8];
        end
        // row r rotates left by r
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_shift[r*4+c] = w_in[r*4 + ((c+r) & 3)];
            end
        end
        w_col = '0;
        for (int c = 0; c < 4; c++) begin
            w_col = mix_column({w_shift[c], w_shift[c+4], w_shift[c+8], w_shift[c+12]});
            w_mix[c]    = w_col[31:24];
            w_mix[c+4]  = w_col[23:16];
            w_mix[c+8]  = w_col[15:8];
            w_mix[c+12] = w_col[7:0];
        end
        n_item = i_item;
        if (i_item.mode == MODE_FULL) begin
            for (int k = 0; k < BYTES; k++) begin
                n_item.state[(BYTES-1-k)*8 +: 8] = w_mix[k];
            end
        end else if (i_item.mode == MODE_FINAL) begin
            for (int k = 0; k < BYTES; k++) begin
                n_item.state[(BYTES-1-k)*8 +: 8] = w_shift[k];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ src/aesr_key_stage.sv @@
// last pipeline stage: addroundkey into the output register
module aesr_key_stage
    import aesr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BLOCK_W-1:0] o_block
);

    logic               r_valid;
    logic [BLOCK_W-1:0] r_block;
    logic [BLOCK_W-1:0] n_block;

    assign n_block = i_item.state ^ i_item.key;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_block = r_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_block <= n_block;
        end
    end

endmodule
